FILE: design/ypcd_pkg.sv
// ----------------------------------------------------------------------------
// ypcd_pkg
// Shared constants, types and tables of the yaw/pitch camera direction block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ypcd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int ROT_STEPS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int IDX_W        = $clog2(ATAN_LEN);

  localparam int DELTA_W   = 16;
  localparam int SENS_W    = 16;
  localparam int LIM_W     = 7;
  localparam int YAW_W     = 25;
  localparam int PITCH_W   = 24;
  localparam int FRONT_W   = 16;
  localparam int Q30_W     = 32;
  localparam int Z_W       = 26;
  localparam int PACC_W    = 32;
  localparam int MUL_STEPS = DELTA_W - 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int IN_W      = 2 * DELTA_W;
  localparam int OUT_BITS  = 3 * FRONT_W + YAW_W + PITCH_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [YAW_W-1:0]        FULL_TURN    = 25'd23592960;
  localparam logic [YAW_W-1:0]        HALF_TURN    = 25'd11796480;
  localparam logic signed [YAW_W-1:0] QUARTER_TURN = 25'sd5898240;
  localparam logic signed [YAW_W-1:0] YAW_RESET    = -25'sd5898240;
  localparam logic [SENS_W-1:0]       SENS_RESET   = 16'd3277;
  localparam logic [LIM_W-1:0]        LIM_MAX      = 7'd89;
  localparam logic signed [Q30_W-1:0] GAIN_Q30     = 32'sd652032874;

  function automatic logic [21:0] atan_q16(input logic [IDX_W-1:0] i);
    case (i)
      5'd0:    return 22'd2949120;
      5'd1:    return 22'd1740967;
      5'd2:    return 22'd919879;
      5'd3:    return 22'd466945;
      5'd4:    return 22'd234379;
      5'd5:    return 22'd117304;
      5'd6:    return 22'd58666;
      5'd7:    return 22'd29335;
      5'd8:    return 22'd14668;
      5'd9:    return 22'd7334;
      5'd10:   return 22'd3667;
      5'd11:   return 22'd1833;
      5'd12:   return 22'd917;
      5'd13:   return 22'd458;
      5'd14:   return 22'd229;
      5'd15:   return 22'd115;
      5'd16:   return 22'd57;
      5'd17:   return 22'd29;
      5'd18:   return 22'd14;
      5'd19:   return 22'd7;
      5'd20:   return 22'd4;
      5'd21:   return 22'd2;
      5'd22:   return 22'd1;
      default: return 22'd0;
    endcase
  endfunction

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS      = 2'd0,
    CFG_PITCH_LIM = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRAP,
    ST_LOAD,
    ST_ROT,
    ST_PROD_C,
    ST_PROD_S,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ang_ctl_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [IDX_W-1:0] idx;
  } rot_ctl_t;

endpackage

`default_nettype wire

FILE: design/ypcd_angle_update.sv
// ----------------------------------------------------------------------------
// ypcd_angle_update
// Bit-serial scaling of the pointer deltas, yaw wrap and pitch clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ypcd_angle_update (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire ypcd_pkg::ang_ctl_t                   ctl,
  input  wire logic signed [ypcd_pkg::DELTA_W-1:0]  delta_x,
  input  wire logic signed [ypcd_pkg::DELTA_W-1:0]  delta_y,
  input  wire logic [ypcd_pkg::SENS_W-1:0]          sens,
  input  wire logic [ypcd_pkg::LIM_W-1:0]           lim,
  output logic signed [ypcd_pkg::YAW_W-1:0]         yaw,
  output logic signed [ypcd_pkg::PITCH_W-1:0]       pitch
);
  import ypcd_pkg::*;

  logic [DELTA_W-2:0]       dxs_r, dxs_nxt;
  logic [DELTA_W-2:0]       dys_r, dys_nxt;
  logic [YAW_W-1:0]         ay_r, ay_nxt;
  logic signed [PACC_W-1:0] ap_r, ap_nxt;
  logic signed [YAW_W-1:0]  yaw_r, yaw_nxt;
  logic signed [PITCH_W-1:0] pitch_r, pitch_nxt;

  logic [YAW_W+1:0]         v;
  logic signed [YAW_W+1:0]  ysum, ywrap;
  logic signed [32:0]       psum, limv;
  logic [LIM_W-1:0]         lim_c;

  always_comb begin
    dxs_nxt   = dxs_r;
    dys_nxt   = dys_r;
    ay_nxt    = ay_r;
    ap_nxt    = ap_r;
    yaw_nxt   = yaw_r;
    pitch_nxt = pitch_r;

    v = {1'b0, ay_r, 1'b0} + {11'b0, (dxs_r[DELTA_W-2] ? sens : '0)};
    ysum = $signed({2'b0, ay_r}) + $signed({{2{yaw_r[YAW_W-1]}}, yaw_r})
         + $signed({2'b0, HALF_TURN});
    ywrap = (ysum >= $signed({2'b0, FULL_TURN})) ? ysum - $signed({2'b0, FULL_TURN}) : ysum;

    lim_c = (lim > LIM_MAX) ? LIM_MAX : lim;
    limv  = $signed({10'b0, lim_c, 16'b0});
    psum  = $signed({{9{pitch_r[PITCH_W-1]}}, pitch_r}) + $signed({ap_r[PACC_W-1], ap_r});

    if (ctl.load) begin
      dxs_nxt = delta_x[DELTA_W-2:0];
      dys_nxt = delta_y[DELTA_W-2:0];
      ay_nxt  = (delta_x[DELTA_W-1] && sens != '0) ? FULL_TURN - {9'b0, sens} : '0;
      ap_nxt  = delta_y[DELTA_W-1] ? 32'sd0 - $signed({16'b0, sens}) : '0;
    end else if (ctl.step) begin
      dxs_nxt = {dxs_r[DELTA_W-3:0], 1'b0};
      dys_nxt = {dys_r[DELTA_W-3:0], 1'b0};
      if (v >= {1'b0, FULL_TURN, 1'b0}) begin
        ay_nxt = YAW_W'(v - {1'b0, FULL_TURN, 1'b0});
      end else if (v >= {2'b0, FULL_TURN}) begin
        ay_nxt = YAW_W'(v - {2'b0, FULL_TURN});
      end else begin
        ay_nxt = YAW_W'(v);
      end
      ap_nxt = (ap_r <<< 1) + $signed({16'b0, (dys_r[DELTA_W-2] ? sens : '0)});
    end else if (ctl.finish) begin
      yaw_nxt = YAW_W'(ywrap - $signed({2'b0, HALF_TURN}));
      if (psum > limv) begin
        pitch_nxt = PITCH_W'(limv);
      end else if (psum < -limv) begin
        pitch_nxt = PITCH_W'(-limv);
      end else begin
        pitch_nxt = PITCH_W'(psum);
      end
    end
  end

  always_ff @(posedge clk) begin
    dxs_r <= dxs_nxt;
    dys_r <= dys_nxt;
    ay_r  <= ay_nxt;
    ap_r  <= ap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= YAW_RESET;
      pitch_r <= '0;
    end else begin
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  assign yaw   = yaw_r;
  assign pitch = pitch_r;

endmodule

`default_nettype wire

FILE: design/ypcd_cordic.sv
// ----------------------------------------------------------------------------
// ypcd_cordic
// Rotation-mode CORDIC in degrees, one iteration per cycle, Q30 sine/cosine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ypcd_cordic (
  input  wire logic                                clk,
  input  wire ypcd_pkg::rot_ctl_t                  ctl,
  input  wire logic signed [ypcd_pkg::YAW_W-1:0]   ang,
  output logic signed [ypcd_pkg::Q30_W-1:0]        sin_q30,
  output logic signed [ypcd_pkg::Q30_W-1:0]        cos_q30
);
  import ypcd_pkg::*;

  logic signed [Q30_W-1:0] x_r, x_nxt;
  logic signed [Q30_W-1:0] y_r, y_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt;
  logic                    flip_r, flip_nxt;

  logic signed [Z_W-1:0]   ang_w, half_w, at;
  logic signed [Q30_W-1:0] sx, sy;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    flip_nxt = flip_r;

    ang_w  = {ang[YAW_W-1], ang};
    half_w = $signed({1'b0, HALF_TURN});
    at     = $signed({4'b0, atan_q16(ctl.idx)});
    sx     = y_r >>> ctl.idx;
    sy     = x_r >>> ctl.idx;

    if (ctl.load) begin
      x_nxt = GAIN_Q30;
      y_nxt = '0;
      if (ang > QUARTER_TURN) begin
        z_nxt    = ang_w - half_w;
        flip_nxt = 1'b1;
      end else if (ang < -QUARTER_TURN) begin
        z_nxt    = ang_w + half_w;
        flip_nxt = 1'b1;
      end else begin
        z_nxt    = ang_w;
        flip_nxt = 1'b0;
      end
    end else if (ctl.step) begin
      if (!z_r[Z_W-1]) begin
        x_nxt = x_r - sx;
        y_nxt = y_r + sy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + sx;
        y_nxt = y_r - sy;
        z_nxt = z_r + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign sin_q30 = flip_r ? -y_r : y_r;
  assign cos_q30 = flip_r ? -x_r : x_r;

endmodule

`default_nettype wire

FILE: design/yaw_pitch_camera_direction.sv
// ----------------------------------------------------------------------------
// yaw_pitch_camera_direction
// First-person camera: pointer deltas turn yaw and pitch, front vector out.
//
// Input stream: in_tdata carries delta_x and delta_y; one transaction per
// pointer event. Output stream: out_tdata carries front_x, front_y, front_z
// (Q1.14), the wrapped yaw and the clamped pitch (degrees, 16 fraction bits).
// Configuration: cfg_index 0 writes sensitivity, 1 writes pitch_limit; other
// indexes are dropped. Write only while the block is idle.
// Sequence: the deltas are scaled bit-serially, then yaw and pitch are
// updated, both CORDICs run CORDIC_STEPS iterations in parallel and one
// shared 32x32 multiplier forms the products for the output register. A
// new item is taken only after the last result has entered that register.
// Reset: yaw returns to minus ninety degrees, pitch to zero, configuration to
// its defaults. A stalled receiver holds the result in the output register;
// the next item is still taken and waits for that register before it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yaw_pitch_camera_direction (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // delta_x [15:0], delta_y [31:16]
  input  wire logic [ypcd_pkg::IN_W-1:0]         in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // front_x [15:0], front_y [31:16], front_z [47:32], yaw_now [72:48],
  // pitch_now [96:73], zero [103:97]
  output logic [ypcd_pkg::OUT_W-1:0]             out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ypcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ypcd_pkg::CFG_W-1:0]        cfg_data
);
  import ypcd_pkg::*;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  logic [SENS_W-1:0] sens_r;
  logic [LIM_W-1:0]  lim_r;

  ang_ctl_t ang_ctl;
  rot_ctl_t rot_ctl;

  logic signed [YAW_W-1:0]   yaw;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [Q30_W-1:0]   sin_y, cos_y, sin_p, cos_p;

  logic signed [63:0]        mul_r;
  logic signed [Q30_W-1:0]   mul_a;
  logic signed [FRONT_W-1:0] res_x_r;
  logic signed [63:0]        rnd_mul, rnd_y;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_free, out_load, in_fire;

  function automatic logic signed [FRONT_W-1:0] sat_q14(input logic signed [63:0] v);
    logic signed [FRONT_W-1:0] r;
    if (v > 64'sd16384) begin
      r = 16'sd16384;
    end else if (v < -64'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = FRONT_W'(v);
    end
    return r;
  endfunction

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(MUL_STEPS - 1)) begin
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: state_nxt = ST_LOAD;
      ST_LOAD: begin
        state_nxt = ST_ROT;
        cnt_nxt   = '0;
      end
      ST_ROT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(ROT_STEPS - 1)) begin
          state_nxt = ST_PROD_C;
        end
      end
      ST_PROD_C: state_nxt = ST_PROD_S;
      ST_PROD_S: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready      = 1'b0;
    ang_ctl        = '0;
    rot_ctl        = '0;
    rot_ctl.idx    = cnt_r;
    out_load       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        ang_ctl.load = in_fire;
      end
      ST_MUL:  ang_ctl.step   = 1'b1;
      ST_WRAP: ang_ctl.finish = 1'b1;
      ST_LOAD: rot_ctl.load   = 1'b1;
      ST_ROT:  rot_ctl.step   = 1'b1;
      ST_OUT:  out_load       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= SENS_RESET;
      lim_r  <= LIM_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SENS:      sens_r <= cfg_data[SENS_W-1:0];
        CFG_PITCH_LIM: lim_r  <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  ypcd_angle_update u_angle (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ang_ctl),
    .delta_x ($signed(in_tdata[DELTA_W-1:0])),
    .delta_y ($signed(in_tdata[2*DELTA_W-1:DELTA_W])),
    .sens    (sens_r),
    .lim     (lim_r),
    .yaw     (yaw),
    .pitch   (pitch)
  );

  ypcd_cordic u_rot_yaw (
    .clk     (clk),
    .ctl     (rot_ctl),
    .ang     (yaw),
    .sin_q30 (sin_y),
    .cos_q30 (cos_y)
  );

  ypcd_cordic u_rot_pitch (
    .clk     (clk),
    .ctl     (rot_ctl),
    .ang     ({pitch[PITCH_W-1], pitch}),
    .sin_q30 (sin_p),
    .cos_q30 (cos_p)
  );

  assign mul_a   = (state_r == ST_PROD_C) ? cos_y : sin_y;
  assign rnd_mul = (mul_r + (64'sd1 <<< 45)) >>> 46;
  assign rnd_y   = ($signed({{32{sin_p[Q30_W-1]}}, sin_p}) + (64'sd1 <<< 15)) >>> 16;

  always_ff @(posedge clk) begin
    if (state_r == ST_PROD_C || state_r == ST_PROD_S) begin
      mul_r <= 64'(mul_a) * 64'(cos_p);
    end
    if (state_r == ST_PROD_S) begin
      res_x_r <= sat_q14(rnd_mul);
    end
    if (out_load) begin
      out_data_r <= OUT_W'({pitch, yaw, sat_q14(rnd_mul), sat_q14(rnd_y), res_x_r});
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[72:48]) >= -$signed({1'b0, HALF_TURN}) &&
                    $signed(out_tdata[72:48]) < $signed({1'b0, HALF_TURN})))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[96:73]) <= 24'sd5832704 &&
                    $signed(out_tdata[96:73]) >= -24'sd5832704))
    else $error("pitch beyond clamp");

  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384 &&
                    $signed(out_tdata[15:0]) >= -16'sd16384 &&
                    $signed(out_tdata[47:32]) <= 16'sd16384 &&
                    $signed(out_tdata[47:32]) >= -16'sd16384))
    else $error("front vector component saturated wrongly");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("result lost at output register");
`endif

endmodule

`default_nettype wire
